// ===== sv/qpd_pkg.sv =====
`timescale 1ns / 1ps
// qpd_pkg: shared constants and types for the QRS peak detector.
// No dependencies; imported by every module of the block.
package qpd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int FEAT_BITS   = 15;
  localparam int WARMUP_BITS = 16;
  localparam int RUN_BITS    = 8;
  localparam int QCOUNT_BITS = 16;

  localparam logic [FEAT_BITS-1:0] FEAT_MAX = {FEAT_BITS{1'b1}};

  // configuration port
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RUN_LEN = 1'd1;

  localparam logic [RUN_BITS-1:0] RUN_LEN_RESET = 8'd5;

  // output word layout
  localparam int OUT_FIELD_BITS = FEAT_BITS + 1 + QCOUNT_BITS + 1;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [WARMUP_BITS-1:0] warmup_samples;
    logic [RUN_BITS-1:0]    peak_run_length;
  } cfg_t;

  typedef struct packed {
    logic                   warming_up;
    logic [QCOUNT_BITS-1:0] qrs_count;
    logic                   qrs_detected;
    logic [FEAT_BITS-1:0]   feature_value;
  } result_t;

endpackage

// ===== sv/qpd_front.sv =====
`timescale 1ns / 1ps
// qpd_front: sample window and Ahlstrom-Tompkins feature (Y3) per sample.
// Depends on qpd_pkg.
module qpd_front import qpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   smp_valid,
  input  logic [SAMPLE_BITS-1:0] smp,
  output logic                   smp_ready,
  output logic                   feat_valid,
  output logic [FEAT_BITS-1:0]   feat,
  input  logic                   feat_ready
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int EW = SAMPLE_BITS + 3;
  localparam int SW = (SAMPLE_BITS + 4 > FEAT_BITS) ? SAMPLE_BITS + 4 : FEAT_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] win_r [4];
  logic signed [SAMPLE_BITS-1:0] x4;
  logic signed [DW-1:0]          d20, d31, d42;
  logic signed [EW-1:0]          d2nd;
  logic        [DW-1:0]          a20, a31, a42;
  logic        [EW-1:0]          a2nd;
  logic        [SW-1:0]          sum;
  logic                          accept;

  assign x4        = $signed(smp);
  assign smp_ready = feat_ready;
  assign accept    = smp_valid & smp_ready;

  // shift the window on every accepted word; slot 3 is the newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else if (accept) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= x4;
    end
  end

  always_comb begin
    d20  = DW'(win_r[2]) - DW'(win_r[0]);
    d31  = DW'(win_r[3]) - DW'(win_r[1]);
    d42  = DW'(x4) - DW'(win_r[2]);
    d2nd = EW'(win_r[0]) - (EW'(win_r[2]) <<< 1) + EW'(x4);
    a20  = d20[DW-1] ? DW'(-d20) : DW'(d20);
    a31  = d31[DW-1] ? DW'(-d31) : DW'(d31);
    a42  = d42[DW-1] ? DW'(-d42) : DW'(d42);
    a2nd = d2nd[EW-1] ? EW'(-d2nd) : EW'(d2nd);
    sum  = SW'(a20) + (SW'(a31) << 1) + SW'(a42) + SW'(a2nd);
  end

  // saturate to the feature width
  assign feat       = (sum > SW'(FEAT_MAX)) ? FEAT_MAX : sum[FEAT_BITS-1:0];
  assign feat_valid = smp_valid;

endmodule

// ===== sv/qpd_queue.sv =====
`timescale 1ns / 1ps
// qpd_queue: two-entry queue of feature words between front and back.
// Depends on qpd_pkg.
module qpd_queue import qpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  input  logic [FEAT_BITS-1:0] wr_data,
  output logic                 wr_ready,
  output logic                 rd_valid,
  output logic [FEAT_BITS-1:0] rd_data,
  input  logic                 rd_ready
);

  logic [FEAT_BITS-1:0] ent_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = ent_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== sv/qpd_back.sv =====
`timescale 1ns / 1ps
// qpd_back: running maximum, thresholds, warm-up, run counting and the
// output register. Depends on qpd_pkg.
module qpd_back import qpd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 feat_valid,
  input  logic [FEAT_BITS-1:0] feat,
  output logic                 feat_ready,
  output logic                 res_valid,
  output result_t              res,
  input  logic                 res_ready
);

  localparam int CW = (COUNT_BITS > QCOUNT_BITS) ? COUNT_BITS : QCOUNT_BITS;

  logic [FEAT_BITS-1:0]   max_r, max_nxt;
  logic                   armed_r, armed_nxt;
  logic [RUN_BITS-1:0]    run_r, run_nxt, run_inc;
  logic [WARMUP_BITS:0]   warm_r, warm_nxt;
  logic [COUNT_BITS-1:0]  total_r, total_nxt;
  logic                   valid_r;
  result_t                res_r, res_nxt;
  logic                   pop, warming, detected, hit_one, hit_two;
  logic [FEAT_BITS+2:0]   y5, m4;
  logic [FEAT_BITS+3:0]   y10;
  logic [CW-1:0]          total_ext;

  assign feat_ready = ~valid_r | res_ready;
  assign pop        = feat_valid & feat_ready;
  assign res_valid  = valid_r;
  assign res        = res_r;

  always_comb begin
    max_nxt = (feat > max_r) ? feat : max_r;
    y5      = (FEAT_BITS+3)'(feat) + ((FEAT_BITS+3)'(feat) << 2);
    m4      = (FEAT_BITS+3)'(max_nxt) << 2;
    y10     = ((FEAT_BITS+4)'(feat) << 3) + ((FEAT_BITS+4)'(feat) << 1);
    hit_one = (y5 >= m4);
    hit_two = (y10 >= (FEAT_BITS+4)'(max_nxt));
    warming = (warm_r <= (WARMUP_BITS+1)'(cfg.warmup_samples));
    run_inc = run_r + 1'b1;

    armed_nxt = armed_r;
    run_nxt   = run_r;
    warm_nxt  = warm_r;
    total_nxt = total_r;
    detected  = 1'b0;

    priority if (warming) begin
      warm_nxt = warm_r + 1'b1;
    end else if (!armed_r) begin
      armed_nxt = hit_one;
    end else if (hit_two) begin
      // count the run; a full run is one detection
      if (run_inc == cfg.peak_run_length) begin
        detected  = 1'b1;
        total_nxt = total_r + 1'b1;
        run_nxt   = '0;
        armed_nxt = 1'b0;
      end else begin
        run_nxt = run_inc;
      end
    end else begin
      run_nxt   = '0;
      armed_nxt = 1'b0;
    end

    total_ext             = CW'(total_nxt);
    res_nxt.feature_value = feat;
    res_nxt.qrs_detected  = detected;
    res_nxt.qrs_count     = total_ext[QCOUNT_BITS-1:0];
    res_nxt.warming_up    = warming;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      armed_r <= 1'b0;
      run_r   <= '0;
      warm_r  <= '0;
      total_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        max_r   <= max_nxt;
        armed_r <= armed_nxt;
        run_r   <= run_nxt;
        warm_r  <= warm_nxt;
        total_r <= total_nxt;
      end
      if (feat_ready) valid_r <= feat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

endmodule

// ===== sv/qrs_peak_detector.sv =====
`timescale 1ns / 1ps
// qrs_peak_detector: top level of the Ahlstrom-Tompkins QRS peak detector.
// Depends on qpd_pkg, qpd_front, qpd_queue and qpd_back.
//
// The block takes one signed sample per input word and returns one result
// word per sample: the feature Y3 computed over the last five samples, a flag
// when that sample completed a QRS detection, the running detection count and
// a flag telling that peak checking was still suppressed by the warm-up. The
// front computes Y3 as the samples arrive and pushes it into a two-entry
// queue; the back pops the queue, tracks the running maximum of Y3, tests
// threshold one (5*Y3 >= 4*max) and threshold two (10*Y3 >= max) and counts
// runs. Each result is registered in a queue entry and then in the output
// register after its sample is accepted, and one sample is taken every cycle
// as long as the output side keeps up; the queue lets the input run on until
// it is full while the output is stalled. Write configuration only while no
// sample is in flight.
module qrs_peak_detector import qpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream; tdata: sample[SAMPLE_BITS-1:0], zero padding above
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // result stream; tdata: feature_value[14:0], qrs_detected[15],
  // qrs_count[31:16], warming_up[32], zero padding above
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_DATA_BITS-1:0]            out_tdata,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_wdata
);

  cfg_t                 cfg_r;
  logic                 fq_valid, fq_ready;
  logic [FEAT_BITS-1:0] fq_data;
  logic                 qb_valid, qb_ready;
  logic [FEAT_BITS-1:0] qb_data;
  result_t              res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_samples  <= '0;
      cfg_r.peak_run_length <= RUN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARMUP:  cfg_r.warmup_samples  <= cfg_wdata[WARMUP_BITS-1:0];
        REG_RUN_LEN: cfg_r.peak_run_length <= cfg_wdata[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: window and feature
  qpd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_valid  (in_tvalid),
    .smp        (in_tdata[SAMPLE_BITS-1:0]),
    .smp_ready  (in_tready),
    .feat_valid (fq_valid),
    .feat       (fq_data),
    .feat_ready (fq_ready)
  );

  // decouple front and back
  qpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_data  (fq_data),
    .wr_ready (fq_ready),
    .rd_valid (qb_valid),
    .rd_data  (qb_data),
    .rd_ready (qb_ready)
  );

  // back: thresholds, counting, output register
  qpd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .feat_valid (qb_valid),
    .feat       (qb_data),
    .feat_ready (qb_ready),
    .res_valid  (out_tvalid),
    .res        (res),
    .res_ready  (out_tready)
  );

  // pack fields from the lowest bit up, pad with zeros
  assign out_tdata = OUT_DATA_BITS'(res);

endmodule

// ===== test/tb_qrs_peak_detector.sv =====
`timescale 1ns / 1ps
// tb_qrs_peak_detector: self-checking testbench for the QRS peak detector.
// Depends on qpd_pkg and qrs_peak_detector; drives sample words, predicts
// every result word in a cycle-free model and checks each result field.
module tb_qrs_peak_detector;
  import qpd_pkg::*;

  localparam int SBITS     = SAMPLE_BITS_DEF;
  localparam int IN_BITS   = ((SBITS + 7) / 8) * 8;
  localparam int ERR_SHOWN = 100;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_BITS-1:0]       in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_WARMUP;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  qrs_peak_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Detector state mirrored by the testbench. Updated once per accepted sample
  // word; register copies change only while nothing is in flight.
  // ---------------------------------------------------------------------------
  int               window_hist[4] = '{0, 0, 0, 0};  // oldest first
  int               peak_max       = 0;
  bit               armed          = 1'b0;
  logic [7:0]       run_cnt        = '0;             // wraps, so length 0 acts as 256
  int               warm_cnt       = 0;              // 17 bits wide in effect
  logic [15:0]      qrs_total      = '0;
  int               warmup_setting = 0;
  logic [7:0]       run_len_setting = RUN_LEN_RESET;

  // Bookkeeping
  logic [SBITS-1:0] sample_queue[$];       // sample words waiting for the driver
  result_t          expected_results[$];   // predicted result words, oldest first
  int               n_queued    = 0;
  int               n_accepted  = 0;
  int               n_results   = 0;
  int               n_detected  = 0;
  int               n_wraps     = 0;
  int               n_settings  = 0;
  int               fail_count  = 0;
  int               idle_pct    = 32;
  bit               in_fired    = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Shift one sample into the window, compute Y3, run the threshold logic and
  // return the result word this sample must produce.
  function automatic result_t detector_step(logic [SBITS-1:0] raw);
    int      x0, x1, x2, x3, x4;
    int      y3;
    bit      warming;
    bit      detected;
    result_t r;
    x0 = window_hist[0];
    x1 = window_hist[1];
    x2 = window_hist[2];
    x3 = window_hist[3];
    x4 = $signed(raw);
    window_hist[0] = x1;
    window_hist[1] = x2;
    window_hist[2] = x3;
    window_hist[3] = x4;
    detected = 1'b0;

    y3 = iabs(x2 - x0) + 2 * iabs(x3 - x1) + iabs(x4 - x2) + iabs(x0 - 2 * x2 + x4);
    if (y3 > int'(FEAT_MAX)) y3 = int'(FEAT_MAX);
    // the maximum tracks every sample, warm-up included
    if (y3 > peak_max) peak_max = y3;

    warming = (warm_cnt <= warmup_setting);
    if (warming) begin
      warm_cnt++;
    end else if (!armed) begin
      if (5 * y3 >= 4 * peak_max) armed = 1'b1;
    end else if (10 * y3 >= peak_max) begin
      run_cnt = run_cnt + 8'd1;
      if (run_cnt == run_len_setting) begin
        qrs_total = qrs_total + 16'd1;
        detected  = 1'b1;
        run_cnt   = '0;
        armed     = 1'b0;
        n_detected++;
        if (qrs_total == '0) n_wraps++;
      end
    end else begin
      run_cnt = '0;
      armed   = 1'b0;
    end

    r.feature_value = y3[FEAT_BITS-1:0];
    r.qrs_detected  = detected;
    r.qrs_count     = qrs_total;
    r.warming_up    = warming;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      // keep the log readable when the block is badly off
      if (fail_count <= ERR_SHOWN)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge. Hold the word while it waits
  // for in_tready; once taken, present the next queued word or idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_tdata  <= IN_BITS'(sample_queue.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_BITS'($urandom_range(0, 4095));
      end
    end
  end

  // Output side: stall at random, same idle rate as the input side.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Capture accepted sample words on the rising edge and predict their results.
  always @(posedge clk) begin
    in_fired = rst_n && in_tvalid && in_tready;
    if (in_fired) begin
      expected_results.push_back(detector_step(in_tdata[SBITS-1:0]));
      n_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_FIELD_BITS-1:0];
      n_results++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("result word with no sample pending (feature_value %0d)", got.feature_value);
      end else begin
        want = expected_results.pop_front();
        check_field("feature_value", want.feature_value, got.feature_value);
        check_field("qrs_detected",  want.qrs_detected,  got.qrs_detected);
        check_field("qrs_count",     want.qrs_count,     got.qrs_count);
        check_field("warming_up",    want.warming_up,    got.warming_up);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_sample(logic [SBITS-1:0] s);
    sample_queue.push_back(s);
    n_queued++;
  endtask

  // Wait until every queued word was taken and every result came back, then
  // allow the two-stage pipe to drain.
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_WARMUP) warmup_setting = value;
    else run_len_setting = value[7:0];
    n_settings++;
  endtask

  // Square wave of period four: Y3 stays at about 12*amp at every phase, so
  // a burst arms and keeps the run going.
  task automatic queue_burst(int amp, int len, int jitter);
    int ph, s;
    ph = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      s = (((i + ph) % 4) < 2) ? amp : -amp - 1;
      if (jitter > 0) s = s + $urandom_range(0, 2 * jitter) - jitter;
      if (s > 2047) s = 2047;
      if (s < -2048) s = -2048;
      queue_sample(s[SBITS-1:0]);
    end
  endtask

  task automatic queue_noise(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 1) != 0) queue_sample($urandom_range(0, 4095));
      else queue_sample($urandom_range(0, 64) - 32);
    end
  endtask

  // Mostly QRS-like bursts sized around the run length, mixed with noise and
  // bursts cut short or too weak to arm.
  task automatic random_phase(int n_items);
    int goal, run_eff, len, amp;
    goal    = n_queued + n_items;
    run_eff = (run_len_setting == 0) ? 256 : run_len_setting;
    while (n_queued < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        len = run_eff + $urandom_range(0, 8) - 3;
        if (len < 1) len = 1;
        if ($urandom_range(0, 9) < 8) amp = $urandom_range(1700, 2047);
        else amp = $urandom_range(20, 1700);
        queue_burst(amp, len, $urandom_range(0, 40));
      end else begin
        queue_noise($urandom_range(1, 8));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: startup window of zeros, full-scale swings that give the
    // largest feature, small values around zero, reset register values.
    queue_sample(0);
    queue_sample(2047);
    queue_sample(2047);
    queue_sample(-2048);
    queue_sample(-2048);
    queue_sample(2047);
    queue_sample(2047);
    queue_sample(-2048);
    queue_sample(-2048);
    queue_sample(2047);
    queue_sample(-1);
    queue_sample(1);
    for (int i = 0; i < 5; i++) queue_sample(0);
    queue_sample(-2048);
    queue_sample(2047);
    queue_sample(-2048);
    queue_sample(2047);
    queue_sample(-1);
    queue_sample(-1);
    queue_sample(2047);

    // Raise the warm-up after it already ran out: checking is suppressed again.
    write_reg(REG_WARMUP, 16'd3);
    write_reg(REG_RUN_LEN, 16'd1);
    random_phase(150);

    // Long stretch with no idling on either side.
    write_reg(REG_WARMUP, 16'd0);
    write_reg(REG_RUN_LEN, 16'd2);
    idle_pct = 0;
    random_phase(120);
    idle_pct = 32;

    // Upper bits of the data word are junk for the 8-bit run length.
    write_reg(REG_WARMUP, 16'd40);
    write_reg(REG_RUN_LEN, {8'($urandom_range(1, 255)), 8'd7});
    random_phase(150);

    write_reg(REG_RUN_LEN, 16'd255);
    random_phase(200);

    // Run length zero wraps the 8-bit run counter, so it acts as 256.
    write_reg(REG_WARMUP, 16'd0);
    write_reg(REG_RUN_LEN, 16'd0);
    random_phase(200);

    // Largest warm-up value suppresses checking again; dropping it back to
    // zero lets peak checking resume.
    write_reg(REG_WARMUP, 16'hFFFF);
    write_reg(REG_RUN_LEN, 16'd3);
    random_phase(60);

    write_reg(REG_WARMUP, 16'd0);
    write_reg(REG_RUN_LEN, 16'd4);
    random_phase(120);

    // Drain, then wait on for a stray word.
    wait_idle();
    repeat (4) @(posedge clk);

    $display("Checked %0d result words for %0d samples across %0d register writes.",
             n_results, n_accepted, n_settings);
    $display("Predicted %0d QRS detections; the detection count wrapped %0d time(s).",
             n_detected, n_wraps);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** qrs_peak_detector: PASSED **");
    end else begin
      $display("** qrs_peak_detector: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run ends well within this time.
  initial begin
    #6_000_000;
    $display("Timeout with %0d results still pending.", expected_results.size());
    $display("** qrs_peak_detector: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qpd_pkg.sv
sv/qpd_front.sv
sv/qpd_queue.sv
sv/qpd_back.sv
sv/qrs_peak_detector.sv
test/tb_qrs_peak_detector.sv
